FILE: sv/guks_pkg.sv
// Package for the grid-balanced keypoint selector.
// Holds the sequencer state type, register indexes and field widths.
// Depends on nothing; used by grid_uniform_keypoint_select_unit.
package guks_pkg;

  // Fixed field widths of the item and configuration ports.
  localparam int unsigned CoordW = 12;
  localparam int unsigned ScoreW = 32;
  localparam int unsigned RankW  = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_MAX_FEATURES  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GRID_COLS     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GRID_ROWS     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_FORCE_UNIFORM = 3'd5;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_LOAD,     // taking keypoints into the store
    S_CLR,      // clearing the cell table
    S_PRE_RD,   // reading a stored keypoint for binning
    S_PRE_LD,   // forming the scaled coordinates
    S_PRE_DIV,  // stepping the cell row and column search
    S_PRE_WR,   // writing the cell of the keypoint
    S_SEL,      // choosing the next kind of pick
    S_CSCAN,    // scanning cells for the least filled one
    S_KSCAN,    // scanning keypoints for the strongest unused one
    S_EXH,      // marking the chosen cell exhausted
    S_COMMIT,   // taking the picked keypoint
    S_FILL_RD,  // reading the fill of the picked keypoint's cell
    S_FILL_WR,  // writing the incremented fill
    S_FINISH    // flushing the held result and closing the frame
  } state_t;

endpackage

FILE: sv/grid_uniform_keypoint_select_unit.sv
// Grid-balanced keypoint selector top level: stores a frame of keypoints, then emits the
// strongest ones, optionally balanced over an image grid. Depends on guks_pkg.
// Keypoints are taken one per cycle when idle; busy is high from the last until selection ends.
// Selection clears the cell table, bins each stored keypoint to a grid cell, then picks strong or
// plain points by a keypoint scan, grid points by a cell scan; empty cells are marked exhausted.
// Points come out one commit late, the last in the first idle cycle; results cannot stall.
// Reset is synchronous, active low, and restores the register reset values and an empty store.
module grid_uniform_keypoint_select_unit #(
  parameter int unsigned MAX_KEYPOINTS = 1024,
  parameter int unsigned MAX_FEATURES  = 64,
  parameter int unsigned MAX_GRID_SIDE = 16,
  parameter int unsigned STRONG_FIRST  = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Keypoint input, command style
  input  logic                          start,
  output logic                          busy,
  input  logic [guks_pkg::CoordW-1:0]   in_key_x,
  input  logic [guks_pkg::CoordW-1:0]   in_key_y,
  input  logic [guks_pkg::ScoreW-1:0]   in_score,
  input  logic                          in_last_key,
  // Selected points, one cycle strobe
  output logic                          out_valid,
  output logic [guks_pkg::CoordW-1:0]   out_feat_x,
  output logic [guks_pkg::CoordW-1:0]   out_feat_y,
  output logic [guks_pkg::RankW-1:0]    out_feat_rank,
  output logic                          out_last_feat,
  // Configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [guks_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [guks_pkg::CfgDataW-1:0] cfg_wdata
);

  localparam int unsigned CW    = guks_pkg::CoordW;
  localparam int unsigned SCW   = guks_pkg::ScoreW;
  localparam int unsigned KW    = (MAX_KEYPOINTS > 1) ? $clog2(MAX_KEYPOINTS) : 1;
  localparam int unsigned KCW   = $clog2(MAX_KEYPOINTS + 1);
  localparam int unsigned NCELL = MAX_GRID_SIDE * MAX_GRID_SIDE;
  localparam int unsigned CLW   = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int unsigned PMAX  = (MAX_KEYPOINTS > NCELL) ? MAX_KEYPOINTS : NCELL;
  localparam int unsigned PW    = $clog2(PMAX + 1);
  localparam int unsigned RW    = (MAX_GRID_SIDE > 1) ? $clog2(MAX_GRID_SIDE) : 1;
  localparam int unsigned SDW   = $clog2(MAX_GRID_SIDE + 1);
  localparam int unsigned LW    = $clog2(MAX_FEATURES + 1);
  localparam int unsigned AW    = CW + SDW + 1;
  localparam int unsigned FW    = 7;
  localparam int unsigned KDW   = 2 * CW + SCW;

  // Configuration registers
  logic [6:0]  max_feat_r;
  logic [4:0]  grid_cols_r, grid_rows_r;
  logic [12:0] img_w_r, img_h_r;
  logic        force_uni_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_feat_r  <= 7'd64;
      grid_cols_r <= 5'd8;
      grid_rows_r <= 5'd8;
      img_w_r     <= 13'd640;
      img_h_r     <= 13'd480;
      force_uni_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        guks_pkg::CFG_MAX_FEATURES:  max_feat_r  <= cfg_wdata[6:0];
        guks_pkg::CFG_GRID_COLS:     grid_cols_r <= cfg_wdata[4:0];
        guks_pkg::CFG_GRID_ROWS:     grid_rows_r <= cfg_wdata[4:0];
        guks_pkg::CFG_IMAGE_WIDTH:   img_w_r     <= cfg_wdata;
        guks_pkg::CFG_IMAGE_HEIGHT:  img_h_r     <= cfg_wdata;
        guks_pkg::CFG_FORCE_UNIFORM: force_uni_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Saturated register values.
  logic [LW-1:0]  limit_c;
  logic [SDW-1:0] cols_c, rows_c;
  logic [12:0]    w_c, h_c;
  logic [PW-1:0]  ncell_c;

  always_comb begin
    if (max_feat_r == 7'd0) limit_c = LW'(1);
    else if (32'(max_feat_r) > MAX_FEATURES) limit_c = LW'(MAX_FEATURES);
    else limit_c = LW'(max_feat_r);
    if (grid_cols_r == 5'd0) cols_c = SDW'(1);
    else if (32'(grid_cols_r) > MAX_GRID_SIDE) cols_c = SDW'(MAX_GRID_SIDE);
    else cols_c = SDW'(grid_cols_r);
    if (grid_rows_r == 5'd0) rows_c = SDW'(1);
    else if (32'(grid_rows_r) > MAX_GRID_SIDE) rows_c = SDW'(MAX_GRID_SIDE);
    else rows_c = SDW'(grid_rows_r);
    if (img_w_r == 13'd0) w_c = 13'd1;
    else if (img_w_r > 13'd4096) w_c = 13'd4096;
    else w_c = img_w_r;
    if (img_h_r == 13'd0) h_c = 13'd1;
    else if (img_h_r > 13'd4096) h_c = 13'd4096;
    else h_c = img_h_r;
    ncell_c = PW'(32'(rows_c) * 32'(cols_c));
  end

  // Control and datapath registers
  guks_pkg::state_t state_r, state_nxt;
  logic [KCW-1:0] key_count_r, key_count_nxt;
  logic [LW-1:0]  emitted_r, emitted_nxt;
  logic [PW-1:0]  ptr_r, ptr_nxt;
  logic           rv_r, rv_nxt;
  logic [PW-1:0]  raddr_d_r, raddr_d_nxt;
  logic           cell_mode_r, cell_mode_nxt;
  logic           found_r, found_nxt;
  logic [SCW-1:0] bscore_r, bscore_nxt;
  logic [KW-1:0]  bidx_r, bidx_nxt;
  logic [CW-1:0]  bx_r, bx_nxt, by_r, by_nxt;
  logic [CLW-1:0] bkcell_r, bkcell_nxt;
  logic [CLW-1:0] bcell_r, bcell_nxt;
  logic [FW-1:0]  bfill_r, bfill_nxt;
  logic [AW-1:0]  ya_r, ya_nxt, xa_r, xa_nxt, acch_r, acch_nxt, accw_r, accw_nxt;
  logic [RW-1:0]  step_r, step_nxt, crow_r, crow_nxt, ccol_r, ccol_nxt;
  logic           pend_v_r, pend_v_nxt;
  logic [CW-1:0]  pend_x_r, pend_x_nxt, pend_y_r, pend_y_nxt;
  logic [guks_pkg::RankW-1:0] pend_rank_r, pend_rank_nxt;
  logic           ov_r, ov_nxt, olast_r, olast_nxt;
  logic [CW-1:0]  ox_r, ox_nxt, oy_r, oy_nxt;
  logic [guks_pkg::RankW-1:0] orank_r, orank_nxt;

  // Memory ports
  logic [KDW-1:0] key_mem [MAX_KEYPOINTS];
  logic           used_mem [MAX_KEYPOINTS];
  logic [CLW-1:0] cell_mem [MAX_KEYPOINTS];
  logic [FW:0]    fill_mem [NCELL];

  logic           key_we, used_we, used_wd, cell_we, fill_we;
  logic [KW-1:0]  key_wa, used_wa, cell_wa, key_ra;
  logic [CLW-1:0] cell_wd, fill_wa, fill_ra;
  logic [FW:0]    fill_wd;
  logic [KDW-1:0] key_rd;
  logic           used_rd;
  logic [CLW-1:0] cell_rd;
  logic [FW:0]    fill_rd;

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= {in_key_x, in_key_y, in_score};
    key_rd <= key_mem[key_ra];
  end

  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_wa] <= used_wd;
    used_rd <= used_mem[key_ra];
  end

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    cell_rd <= cell_mem[key_ra];
  end

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
    fill_rd <= fill_mem[fill_ra];
  end

  // Fields of the stored keypoint read back
  logic [CW-1:0]  rd_x, rd_y;
  logic [SCW-1:0] rd_score;
  assign rd_x     = key_rd[KDW-1 -: CW];
  assign rd_y     = key_rd[SCW +: CW];
  assign rd_score = key_rd[SCW-1:0];

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != guks_pkg::S_LOAD);

  logic scan_end_k, scan_end_c;
  assign scan_end_k = (ptr_r == PW'(key_count_r)) && !rv_r;
  assign scan_end_c = (ptr_r == ncell_c) && !rv_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      guks_pkg::S_LOAD:    if (accept && in_last_key) state_nxt = guks_pkg::S_CLR;
      guks_pkg::S_CLR:     if (ptr_r == PW'(NCELL - 1)) state_nxt = guks_pkg::S_PRE_RD;
      guks_pkg::S_PRE_RD: begin
        if (ptr_r == PW'(key_count_r)) state_nxt = guks_pkg::S_SEL;
        else state_nxt = guks_pkg::S_PRE_LD;
      end
      guks_pkg::S_PRE_LD:  state_nxt = guks_pkg::S_PRE_DIV;
      guks_pkg::S_PRE_DIV: if (step_r == RW'(MAX_GRID_SIDE - 1)) state_nxt = guks_pkg::S_PRE_WR;
      guks_pkg::S_PRE_WR:  state_nxt = guks_pkg::S_PRE_RD;
      guks_pkg::S_SEL: begin
        if (emitted_r == limit_c) state_nxt = guks_pkg::S_FINISH;
        else if (force_uni_r && (32'(emitted_r) >= STRONG_FIRST))
          state_nxt = guks_pkg::S_CSCAN;
        else state_nxt = guks_pkg::S_KSCAN;
      end
      guks_pkg::S_CSCAN: begin
        if (scan_end_c) state_nxt = found_r ? guks_pkg::S_KSCAN : guks_pkg::S_FINISH;
      end
      guks_pkg::S_KSCAN: begin
        if (scan_end_k) begin
          if (found_r) state_nxt = guks_pkg::S_COMMIT;
          else if (cell_mode_r) state_nxt = guks_pkg::S_EXH;
          else state_nxt = guks_pkg::S_FINISH;
        end
      end
      guks_pkg::S_EXH:     state_nxt = guks_pkg::S_SEL;
      guks_pkg::S_COMMIT:  state_nxt = guks_pkg::S_FILL_RD;
      guks_pkg::S_FILL_RD: state_nxt = guks_pkg::S_FILL_WR;
      guks_pkg::S_FILL_WR: state_nxt = guks_pkg::S_SEL;
      guks_pkg::S_FINISH:  state_nxt = guks_pkg::S_LOAD;
      default:             state_nxt = guks_pkg::S_LOAD;
    endcase
  end

  // Datapath, memory controls and outputs
  always_comb begin
    key_count_nxt = key_count_r;
    emitted_nxt   = emitted_r;
    ptr_nxt       = ptr_r;
    rv_nxt        = 1'b0;
    raddr_d_nxt   = ptr_r;
    cell_mode_nxt = cell_mode_r;
    found_nxt     = found_r;
    bscore_nxt    = bscore_r;
    bidx_nxt      = bidx_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    bkcell_nxt    = bkcell_r;
    bcell_nxt     = bcell_r;
    bfill_nxt     = bfill_r;
    ya_nxt        = ya_r;
    xa_nxt        = xa_r;
    acch_nxt      = acch_r;
    accw_nxt      = accw_r;
    step_nxt      = step_r;
    crow_nxt      = crow_r;
    ccol_nxt      = ccol_r;
    pend_v_nxt    = pend_v_r;
    pend_x_nxt    = pend_x_r;
    pend_y_nxt    = pend_y_r;
    pend_rank_nxt = pend_rank_r;
    ov_nxt        = 1'b0;
    olast_nxt     = 1'b0;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    orank_nxt     = orank_r;
    key_we   = 1'b0;
    key_wa   = key_count_r[KW-1:0];
    key_ra   = ptr_r[KW-1:0];
    used_we  = 1'b0;
    used_wa  = key_count_r[KW-1:0];
    used_wd  = 1'b0;
    cell_we  = 1'b0;
    cell_wa  = ptr_r[KW-1:0];
    cell_wd  = CLW'(32'(crow_r) * 32'(cols_c) + 32'(ccol_r));
    fill_we  = 1'b0;
    fill_wa  = ptr_r[CLW-1:0];
    fill_wd  = '0;
    fill_ra  = ptr_r[CLW-1:0];

    unique case (state_r)
      guks_pkg::S_LOAD: begin
        ptr_nxt = '0;
        if (accept) begin
          // A full store drops the item; a last item still starts selection.
          if (key_count_r != KCW'(MAX_KEYPOINTS)) begin
            key_we        = 1'b1;
            used_we       = 1'b1;
            key_count_nxt = key_count_r + KCW'(1);
          end
          emitted_nxt = '0;
          pend_v_nxt  = 1'b0;
        end
      end
      guks_pkg::S_CLR: begin
        fill_we = 1'b1;
        ptr_nxt = (ptr_r == PW'(NCELL - 1)) ? '0 : ptr_r + PW'(1);
      end
      guks_pkg::S_PRE_RD: begin
        if (ptr_r == PW'(key_count_r)) begin
          ptr_nxt = '0;
        end
      end
      guks_pkg::S_PRE_LD: begin
        ya_nxt   = AW'(32'(rd_y) * 32'(rows_c));
        xa_nxt   = AW'(32'(rd_x) * 32'(cols_c));
        acch_nxt = '0;
        accw_nxt = '0;
        step_nxt = '0;
        crow_nxt = '0;
        ccol_nxt = '0;
      end
      guks_pkg::S_PRE_DIV: begin
        // Largest step below the grid side whose multiple of the size fits.
        if ((32'(step_r) < 32'(rows_c)) && (acch_r <= ya_r)) crow_nxt = step_r;
        if ((32'(step_r) < 32'(cols_c)) && (accw_r <= xa_r)) ccol_nxt = step_r;
        acch_nxt = acch_r + AW'(h_c);
        accw_nxt = accw_r + AW'(w_c);
        step_nxt = step_r + RW'(1);
      end
      guks_pkg::S_PRE_WR: begin
        cell_we = 1'b1;
        ptr_nxt = ptr_r + PW'(1);
      end
      guks_pkg::S_SEL: begin
        ptr_nxt       = '0;
        found_nxt     = 1'b0;
        cell_mode_nxt = 1'b0;
      end
      guks_pkg::S_CSCAN: begin
        if (ptr_r != ncell_c) begin
          rv_nxt  = 1'b1;
          ptr_nxt = ptr_r + PW'(1);
        end
        // First cell of smallest fill that is not exhausted.
        if (rv_r && !fill_rd[FW] && (!found_r || (fill_rd[FW-1:0] < bfill_r))) begin
          found_nxt = 1'b1;
          bcell_nxt = raddr_d_r[CLW-1:0];
          bfill_nxt = fill_rd[FW-1:0];
        end
        if (scan_end_c) begin
          ptr_nxt       = '0;
          found_nxt     = 1'b0;
          cell_mode_nxt = 1'b1;
        end
      end
      guks_pkg::S_KSCAN: begin
        if (ptr_r != PW'(key_count_r)) begin
          rv_nxt  = 1'b1;
          ptr_nxt = ptr_r + PW'(1);
        end
        // Strict compare keeps the earliest of equal scores.
        if (rv_r && !used_rd && (!cell_mode_r || (cell_rd == bcell_r)) &&
            (!found_r || (rd_score > bscore_r))) begin
          found_nxt  = 1'b1;
          bscore_nxt = rd_score;
          bidx_nxt   = raddr_d_r[KW-1:0];
          bx_nxt     = rd_x;
          by_nxt     = rd_y;
          bkcell_nxt = cell_rd;
        end
      end
      guks_pkg::S_EXH: begin
        fill_we = 1'b1;
        fill_wa = bcell_r;
        fill_wd = {1'b1, bfill_r};
      end
      guks_pkg::S_COMMIT: begin
        used_we = 1'b1;
        used_wa = bidx_r;
        used_wd = 1'b1;
        // The held point is known not to be last once another is found.
        if (pend_v_r) begin
          ov_nxt    = 1'b1;
          ox_nxt    = pend_x_r;
          oy_nxt    = pend_y_r;
          orank_nxt = pend_rank_r;
        end
        pend_v_nxt    = 1'b1;
        pend_x_nxt    = bx_r;
        pend_y_nxt    = by_r;
        pend_rank_nxt = guks_pkg::RankW'(emitted_r);
        emitted_nxt   = emitted_r + LW'(1);
      end
      guks_pkg::S_FILL_RD: begin
        fill_ra = bkcell_r;
      end
      guks_pkg::S_FILL_WR: begin
        fill_we = 1'b1;
        fill_wa = bkcell_r;
        fill_wd = {fill_rd[FW], fill_rd[FW-1:0] + FW'(1)};
      end
      guks_pkg::S_FINISH: begin
        if (pend_v_r) begin
          ov_nxt    = 1'b1;
          olast_nxt = 1'b1;
          ox_nxt    = pend_x_r;
          oy_nxt    = pend_y_r;
          orank_nxt = pend_rank_r;
        end
        pend_v_nxt    = 1'b0;
        key_count_nxt = '0;
      end
      default: ;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= guks_pkg::S_LOAD;
      key_count_r <= '0;
      emitted_r   <= '0;
      ptr_r       <= '0;
      rv_r        <= 1'b0;
      cell_mode_r <= 1'b0;
      found_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      ov_r        <= 1'b0;
      olast_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_count_r <= key_count_nxt;
      emitted_r   <= emitted_nxt;
      ptr_r       <= ptr_nxt;
      rv_r        <= rv_nxt;
      cell_mode_r <= cell_mode_nxt;
      found_r     <= found_nxt;
      pend_v_r    <= pend_v_nxt;
      ov_r        <= ov_nxt;
      olast_r     <= olast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raddr_d_r   <= raddr_d_nxt;
    bscore_r    <= bscore_nxt;
    bidx_r      <= bidx_nxt;
    bx_r        <= bx_nxt;
    by_r        <= by_nxt;
    bkcell_r    <= bkcell_nxt;
    bcell_r     <= bcell_nxt;
    bfill_r     <= bfill_nxt;
    ya_r        <= ya_nxt;
    xa_r        <= xa_nxt;
    acch_r      <= acch_nxt;
    accw_r      <= accw_nxt;
    step_r      <= step_nxt;
    crow_r      <= crow_nxt;
    ccol_r      <= ccol_nxt;
    pend_x_r    <= pend_x_nxt;
    pend_y_r    <= pend_y_nxt;
    pend_rank_r <= pend_rank_nxt;
    ox_r        <= ox_nxt;
    oy_r        <= oy_nxt;
    orank_r     <= orank_nxt;
  end

  assign out_valid     = ov_r;
  assign out_last_feat = olast_r;
  assign out_feat_x    = ox_r;
  assign out_feat_y    = oy_r;
  assign out_feat_rank = orank_r;

`ifndef SYNTHESIS
  // The final point of a frame comes out as the block returns to loading.
  a_last_at_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_feat) |-> (state_r == guks_pkg::S_LOAD))
    else $error("last point not followed by return to loading");

  // A point that is not last is only shown while selection still runs.
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_feat) |-> busy)
    else $error("intermediate point shown while idle");

  // The number of points taken never passes the limit.
  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (emitted_r <= limit_c))
    else $error("emitted count beyond limit");

  // The fill increment write always follows the read of its cell.
  a_fill_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == guks_pkg::S_FILL_WR) |-> ($past(state_r) == guks_pkg::S_FILL_RD))
    else $error("fill write without its read");
`endif

endmodule
